### sv/bqf_pkg.sv
package bqf_pkg;

  // Delay line word, fixed by the filter's state format.
  localparam int DELAY_WIDTH = 32;

  // Integer bits of every coefficient (Q4.x); the rest are fraction bits.
  localparam int COEF_INT_BITS = 4;

  // Configuration register index.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FF_COEF_0 = 3'd0;
  localparam cfg_idx_t REG_FF_COEF_1 = 3'd1;
  localparam cfg_idx_t REG_FF_COEF_2 = 3'd2;
  localparam cfg_idx_t REG_FB_COEF_1 = 3'd3;
  localparam cfg_idx_t REG_FB_COEF_2 = 3'd4;

endpackage

### sv/bqf_if.sv
// Input sample channel.
interface bqf_sample_in_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// Output sample channel.
interface bqf_sample_out_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// Coefficient write channel.
interface bqf_cfg_if #(
  parameter int COEF_WIDTH = 28
) ();
  logic                  valid;
  logic                  ready;
  bqf_pkg::cfg_idx_t     index;
  logic [COEF_WIDTH-1:0] value;

  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

### sv/biquad_filter_core.sv
// Biquad IIR filter, direct form II, fixed point.
//
// Channels: sample_in_i takes one signed sample item per handshake,
// sample_out_o gives one filtered, saturated sample item for each of them,
// in order. cfg_i writes the five Q4.x coefficients (index 0..4: ff0, ff1,
// ff2, fb1, fb2); other indexes are dropped. cfg_i is always ready; write
// it only while no sample is in flight.
//
// Sequencing: all five products go through one shared shift-add
// multiplier that retires one coefficient bit per cycle; each product takes
// a load step, one step per coefficient bit, and an accumulate step. A new
// item is taken only once the previous result has been registered.
//
// Reset clears the coefficients, the delay line and the output valid flag.
// When the receiver stalls, the output register holds its item; a new
// sample is still accepted and computed, and its result waits in the final
// step until the output register is free.
module biquad_filter_core #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bqf_sample_in_if.sink      sample_in_i,
  bqf_sample_out_if.source   sample_out_o,
  bqf_cfg_if.sink            cfg_i
);

  localparam int DW      = bqf_pkg::DELAY_WIDTH;
  localparam int FRAC    = COEF_WIDTH - bqf_pkg::COEF_INT_BITS;
  // Full product plus one guard bit from the serial accumulator.
  localparam int PROD_W  = DW + 1 + COEF_WIDTH;
  localparam int RND_W   = PROD_W - FRAC;
  // Room for three rounded products, or for the input sample plus two.
  localparam int ACC_W   = RND_W + 2;
  localparam int CNT_W   = (COEF_WIDTH > 1) ? $clog2(COEF_WIDTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_ACC  = 6'b001000,
    S_W0   = 6'b010000,
    S_Y    = 6'b100000
  } state_e;

  // Product order: the two feedback terms first, then the three feedforward terms.
  localparam logic [2:0] STEP_FB1 = 3'd0;
  localparam logic [2:0] STEP_FB2 = 3'd1;
  localparam logic [2:0] STEP_FF0 = 3'd2;
  localparam logic [2:0] STEP_FF1 = 3'd3;
  localparam logic [2:0] STEP_FF2 = 3'd4;

  state_e state_q, state_d;

  // Coefficients.
  logic [COEF_WIDTH-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;

  // Delay line and current delay value.
  logic [DW-1:0] d1_q, d2_q, w0_q;

  // Serial multiplier: hi holds the running partial sum, lo shifts the
  // coefficient out and the low product bits in.
  logic [DW-1:0]         m_q;
  logic [DW:0]           hi_q;
  logic [COEF_WIDTH-1:0] lo_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [2:0]            step_q;

  logic signed [ACC_W-1:0] acc_q;

  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;

  // Operand select for the current step.
  logic [DW-1:0]         op_m;
  logic [COEF_WIDTH-1:0] op_c;
  logic                  op_neg;

  always_comb begin
    case (step_q)
      STEP_FB1: begin op_m = d1_q; op_c = fb1_q; op_neg = 1'b1; end
      STEP_FB2: begin op_m = d2_q; op_c = fb2_q; op_neg = 1'b1; end
      STEP_FF0: begin op_m = w0_q; op_c = ff0_q; op_neg = 1'b0; end
      STEP_FF1: begin op_m = d1_q; op_c = ff1_q; op_neg = 1'b0; end
      STEP_FF2: begin op_m = d2_q; op_c = ff2_q; op_neg = 1'b0; end
      default:  begin op_m = d2_q; op_c = ff2_q; op_neg = 1'b0; end
    endcase
  end

  // One multiplier bit: the coefficient's top bit carries negative weight.
  logic                    mul_last;
  logic signed [DW+1:0]    m_ext, hi_ext, addend, mul_sum;

  assign mul_last = (cnt_q == CNT_W'(COEF_WIDTH - 1));
  assign m_ext    = {{2{m_q[DW-1]}}, m_q};
  assign hi_ext   = {hi_q[DW], hi_q};
  assign addend   = lo_q[0] ? (mul_last ? -m_ext : m_ext) : '0;
  assign mul_sum  = hi_ext + addend;

  // Round half up: floor of the shifted product plus the first dropped bit.
  logic [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0] rnd;

  assign prod = {hi_q, lo_q};
  assign rnd  = $signed({{(ACC_W-RND_W){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC]})
              + $signed({{(ACC_W-1){1'b0}}, prod[FRAC-1]});

  // Saturation of the accumulator to the delay word and to the sample word.
  logic          w0_ovf;
  logic [DW-1:0] w0_sat;
  logic                    y_ovf;
  logic [SAMPLE_WIDTH-1:0] y_sat;

  assign w0_ovf = !((&acc_q[ACC_W-1:DW-1]) || !(|acc_q[ACC_W-1:DW-1]));
  assign w0_sat = w0_ovf ? {acc_q[ACC_W-1], {(DW-1){~acc_q[ACC_W-1]}}} : acc_q[DW-1:0];

  assign y_ovf = !((&acc_q[ACC_W-1:SAMPLE_WIDTH-1]) || !(|acc_q[ACC_W-1:SAMPLE_WIDTH-1]));
  assign y_sat = y_ovf ? {acc_q[ACC_W-1], {(SAMPLE_WIDTH-1){~acc_q[ACC_W-1]}}}
                       : acc_q[SAMPLE_WIDTH-1:0];

  // Handshakes.
  logic in_fire, out_free, out_load;

  assign sample_in_i.ready   = (state_q == S_IDLE);
  assign in_fire             = sample_in_i.valid && sample_in_i.ready;
  assign out_free            = !out_valid_q || sample_out_o.ready;
  assign out_load            = (state_q == S_Y) && out_free;
  assign sample_out_o.valid  = out_valid_q;
  assign sample_out_o.sample_out = out_data_q;
  assign cfg_i.ready         = 1'b1;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_LOAD;
      S_LOAD: state_d = S_MUL;
      S_MUL:  if (mul_last) state_d = S_ACC;
      S_ACC: begin
        if (step_q == STEP_FB2) begin
          state_d = S_W0;
        end else if (step_q == STEP_FF2) begin
          state_d = S_Y;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_W0:   state_d = S_LOAD;
      S_Y:    if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= STEP_FB1;
      cnt_q       <= '0;
      ff0_q       <= '0;
      ff1_q       <= '0;
      ff2_q       <= '0;
      fb1_q       <= '0;
      fb2_q       <= '0;
      d1_q        <= '0;
      d2_q        <= '0;
    end else begin
      state_q <= state_d;

      // Coefficient writes; unknown indexes are dropped.
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          bqf_pkg::REG_FF_COEF_0: ff0_q <= cfg_i.value;
          bqf_pkg::REG_FF_COEF_1: ff1_q <= cfg_i.value;
          bqf_pkg::REG_FF_COEF_2: ff2_q <= cfg_i.value;
          bqf_pkg::REG_FB_COEF_1: fb1_q <= cfg_i.value;
          bqf_pkg::REG_FB_COEF_2: fb2_q <= cfg_i.value;
          default: ;
        endcase
      end

      if (in_fire) step_q <= STEP_FB1;

      if (state_q == S_LOAD) cnt_q <= '0;
      if (state_q == S_MUL)  cnt_q <= cnt_q + CNT_W'(1);

      // Advance to the next product after accumulating this one.
      if (state_q == S_ACC) step_q <= step_q + 3'd1;

      // Shift the delay line as the result leaves.
      if (out_load) begin
        d2_q <= d1_q;
        d1_q <= w0_q;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (sample_out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc_q <= $signed({{(ACC_W-SAMPLE_WIDTH){sample_in_i.sample_in[SAMPLE_WIDTH-1]}},
                        sample_in_i.sample_in});
    end

    if (state_q == S_LOAD) begin
      m_q  <= op_m;
      hi_q <= '0;
      lo_q <= op_c;
    end

    if (state_q == S_MUL) begin
      hi_q <= mul_sum[DW+1:1];
      lo_q <= {mul_sum[0], lo_q[COEF_WIDTH-1:1]};
    end

    if (state_q == S_ACC) begin
      acc_q <= op_neg ? (acc_q - rnd) : (acc_q + rnd);
    end

    // Clamp the new delay value and start the output sum from zero.
    if (state_q == S_W0) begin
      w0_q  <= w0_sat;
      acc_q <= '0;
    end

    if (out_load) out_data_q <= y_sat;
  end

endmodule
